FILE: hdl/sgi_rle_row_decoder_top_assert.svh
// Assertion macros for the SGI RLE row decoder.
`ifndef SGI_RLE_ROW_DECODER_TOP_ASSERT_SVH
`define SGI_RLE_ROW_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SRRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srrd assertion failed");

// Next-cycle implication, disabled while in reset.
`define SRRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srrd assertion failed");

`endif

FILE: hdl/srrd_pkg.sv
// Shared widths and helpers for the SGI RLE row decoder.
`default_nettype none

package srrd_pkg;

   localparam int BYTE_W    = 8;
   localparam int BUDGET_W  = 17;
   localparam int COLUMN_W  = 16;
   localparam int LANES     = 4;
   localparam int WORD_W    = LANES * BYTE_W;
   localparam int COUNT_W   = 3;
   localparam int RUN_W     = 7;

   localparam logic [RUN_W-1:0]    CTRL_COUNT_MASK = 7'h7f;
   localparam int                  CTRL_LIT_BIT    = 7;
   localparam logic [COLUMN_W-1:0] ROW_WIDTH_RESET = 16'hffff;

   // Keep the low lanes bytes of a word, clear the rest.
   function automatic logic [WORD_W-1:0] lane_mask(input logic [COUNT_W-1:0] lanes);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < LANES; i++) begin
         if (COUNT_W'(i) < lanes) begin
            m[i*BYTE_W +: BYTE_W] = '1;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/srrd_req_if.sv
// Input channel: compressed row byte stream.
`default_nettype none

interface srrd_req_if
   import srrd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                row_start;
   logic [BUDGET_W-1:0] row_budget;

   modport source (output valid, output data_byte, output row_start,
                   output row_budget, input ready);
   modport sink   (input valid, input data_byte, input row_start,
                   input row_budget, output ready);
endinterface

`default_nettype wire

FILE: hdl/srrd_rsp_if.sv
// Result channel: packed decoded pixel bytes.
`default_nettype none

interface srrd_rsp_if
   import srrd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   pixel_bytes;
   logic [COUNT_W-1:0]  byte_count;
   logic [COLUMN_W-1:0] start_column;
   logic                row_end;
   logic                last;
   logic                overrun;

   modport source (output valid, output pixel_bytes, output byte_count,
                   output start_column, output row_end, output last,
                   output overrun, input ready);
   modport sink   (input valid, input pixel_bytes, input byte_count,
                   input start_column, input row_end, input last,
                   input overrun, output ready);
endinterface

`default_nettype wire

FILE: hdl/sgi_rle_row_decoder_top.sv
// SGI RLE8 row decoder: one compressed byte in, packed pixel bytes out.
//
// req_chan carries one compressed byte per transfer; row_start marks the
// control byte that opens a row and loads row_budget (data bytes allowed).
// rsp_chan carries up to four decoded bytes per transfer, lane 0 first, with
// the row column of lane 0, row_end, last (final result of that input byte)
// and overrun (bytes past row_width were dropped).
// csr_wr_en/csr_wr_data write row_width; only write while the block is idle.
//
// A result is loaded into the output register in the cycle after the input
// transfer. A stream of control bytes, literal bytes and row terminators flows
// at one byte per cycle while rsp_chan does not stall. A repeat data byte with
// kept bytes starts a run that is emitted up to four lanes per cycle, while
// rsp_chan does not stall, by a single column adder / lane counter, and
// req_chan.ready stays low until the last group is in the output register.
// A stall on rsp_chan holds the output register and, once it is full, stops
// both the run emitter and input transfers; nothing is lost.
// Reset (synchronous, active high) returns to idle with column, budget and
// run count cleared, row_width = 65535 and the output register empty.
`default_nettype none

`include "sgi_rle_row_decoder_top_assert.svh"

module sgi_rle_row_decoder_top
   import srrd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [COLUMN_W-1:0] csr_wr_data,
   srrd_req_if.sink                 req_chan,
   srrd_rsp_if.source               rsp_chan
);

   // phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CTRL = 2'd1;
   localparam logic [1:0] PH_LIT  = 2'd2;
   localparam logic [1:0] PH_REP  = 2'd3;

   // decoder state
   logic [1:0]          phase_ff,     phase_in;
   logic [RUN_W-1:0]    run_ff,       run_in;
   logic [BUDGET_W-1:0] budget_ff,    budget_in;
   logic [COLUMN_W-1:0] column_ff,    column_in;
   logic [COLUMN_W-1:0] row_width_ff, row_width_in;

   // repeat run emitter
   logic                emit_ff,      emit_in;
   logic [RUN_W-1:0]    keep_ff,      keep_in;
   logic [BYTE_W-1:0]   rep_byte_ff,  rep_byte_in;
   logic                rep_ovr_ff,   rep_ovr_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   pix_ff,       pix_in;
   logic [COUNT_W-1:0]  cnt_ff,       cnt_in;
   logic [COLUMN_W-1:0] scol_ff,      scol_in;
   logic                rend_ff,      rend_in;
   logic                last_ff,      last_in;
   logic                ovr_ff,       ovr_in;

   logic                out_free;
   logic                req_ready;
   logic                accept;
   logic                load;
   logic [1:0]          ph_eff;
   logic [BUDGET_W-1:0] bud_eff;
   logic [COLUMN_W-1:0] col_eff;
   logic [COLUMN_W-1:0] avail;
   logic [RUN_W-1:0]    keep;
   logic                keep_ovr;
   logic [COUNT_W-1:0]  lanes;
   logic [RUN_W-1:0]    keep_left;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = !emit_ff && out_free;
   assign accept    = req_chan.valid && req_ready;

   // row_start restarts the row before the byte is looked at
   assign ph_eff  = req_chan.row_start ? PH_CTRL : phase_ff;
   assign bud_eff = req_chan.row_start ? req_chan.row_budget : budget_ff;
   assign col_eff = req_chan.row_start ? '0 : column_ff;

   // room left in the row for a repeat run
   assign avail    = (row_width_ff > col_eff) ? (row_width_ff - col_eff) : '0;
   assign keep     = ({{(COLUMN_W-RUN_W){1'b0}}, run_ff} < avail) ? run_ff
                                                                  : avail[RUN_W-1:0];
   assign keep_ovr = keep < run_ff;

   // emitter step: up to four lanes a cycle while the output register is free
   assign lanes     = (keep_ff >= RUN_W'(LANES)) ? COUNT_W'(LANES) : keep_ff[COUNT_W-1:0];
   assign keep_left = keep_ff - {{(RUN_W-COUNT_W){1'b0}}, lanes};

   always_comb begin
      phase_in     = phase_ff;
      run_in       = run_ff;
      budget_in    = budget_ff;
      column_in    = column_ff;
      row_width_in = csr_wr_en ? csr_wr_data : row_width_ff;
      emit_in      = emit_ff;
      keep_in      = keep_ff;
      rep_byte_in  = rep_byte_ff;
      rep_ovr_in   = rep_ovr_ff;
      load         = 1'b0;
      pix_in       = '0;
      cnt_in       = '0;
      scol_in      = col_eff;
      rend_in      = 1'b0;
      last_in      = 1'b1;
      ovr_in       = 1'b0;

      if (accept) begin
         phase_in  = ph_eff;
         budget_in = bud_eff;
         column_in = col_eff;
         case (ph_eff)
            PH_CTRL: begin
               if ((req_chan.data_byte[RUN_W-1:0] & CTRL_COUNT_MASK) == '0) begin
                  // terminator
                  phase_in = PH_IDLE;
                  load     = 1'b1;
                  rend_in  = 1'b1;
               end else begin
                  run_in   = req_chan.data_byte[RUN_W-1:0] & CTRL_COUNT_MASK;
                  phase_in = req_chan.data_byte[CTRL_LIT_BIT] ? PH_LIT : PH_REP;
               end
            end
            PH_LIT: begin
               load   = 1'b1;
               run_in = run_ff - RUN_W'(1);
               if (bud_eff == '0) begin
                  // budget exhausted: byte still kept, row ends
                  rend_in  = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  budget_in = bud_eff - BUDGET_W'(1);
                  if (run_ff == RUN_W'(1)) begin
                     phase_in = PH_CTRL;
                  end
               end
               if (col_eff < row_width_ff) begin
                  pix_in    = {{(WORD_W-BYTE_W){1'b0}}, req_chan.data_byte};
                  cnt_in    = COUNT_W'(1);
                  column_in = col_eff + COLUMN_W'(1);
               end else begin
                  ovr_in = 1'b1;
               end
            end
            PH_REP: begin
               run_in = '0;
               if (bud_eff == '0) begin
                  // budget exhausted: run discarded, row ends
                  phase_in = PH_IDLE;
                  load     = 1'b1;
                  rend_in  = 1'b1;
               end else begin
                  budget_in = bud_eff - BUDGET_W'(1);
                  phase_in  = PH_CTRL;
                  if (keep == '0) begin
                     load   = 1'b1;
                     ovr_in = keep_ovr;
                  end else begin
                     emit_in     = 1'b1;
                     keep_in     = keep;
                     rep_byte_in = req_chan.data_byte;
                     rep_ovr_in  = keep_ovr;
                  end
               end
            end
            default: begin
               // idle, byte without row_start is dropped
            end
         endcase
      end else if (emit_ff && out_free) begin
         load      = 1'b1;
         pix_in    = {LANES{rep_byte_ff}} & lane_mask(lanes);
         cnt_in    = lanes;
         scol_in   = column_ff;
         column_in = column_ff + {{(COLUMN_W-COUNT_W){1'b0}}, lanes};
         keep_in   = keep_left;
         last_in   = keep_left == '0;
         ovr_in    = (keep_left == '0) && rep_ovr_ff;
         emit_in   = keep_left != '0;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         run_ff       <= '0;
         budget_ff    <= '0;
         column_ff    <= '0;
         row_width_ff <= ROW_WIDTH_RESET;
         emit_ff      <= 1'b0;
         keep_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         budget_ff    <= budget_in;
         column_ff    <= column_in;
         row_width_ff <= row_width_in;
         emit_ff      <= emit_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_byte_ff <= rep_byte_in;
      rep_ovr_ff  <= rep_ovr_in;
      if (load) begin
         pix_ff  <= pix_in;
         cnt_ff  <= cnt_in;
         scol_ff <= scol_in;
         rend_ff <= rend_in;
         last_ff <= last_in;
         ovr_ff  <= ovr_in;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_bytes  = pix_ff;
   assign rsp_chan.byte_count   = cnt_ff;
   assign rsp_chan.start_column = scol_ff;
   assign rsp_chan.row_end      = rend_ff;
   assign rsp_chan.last         = last_ff;
   assign rsp_chan.overrun      = ovr_ff;

   // no input while a run is being emitted
   `SRRD_ASSERT_NOW(a_emit_blocks_input, clock, reset, emit_ff, !req_chan.ready)
   // an active run always has bytes left
   `SRRD_ASSERT_NOW(a_emit_nonempty, clock, reset, emit_ff, keep_ff != '0)
   // final group of a run ends emission
   `SRRD_ASSERT_NEXT(a_emit_done, clock, reset,
                     emit_ff && out_free && (keep_ff <= RUN_W'(LANES)), !emit_ff)
   // a result never carries more than four lanes
   `SRRD_ASSERT_NOW(a_count_range, clock, reset, rsp_valid_ff,
                    cnt_ff <= COUNT_W'(LANES))

endmodule

`default_nettype wire

FILE: bench/sgi_rle_row_decoder_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SGI RLE8 row decoder top level.

module sgi_rle_row_decoder_top_test;
   import srrd_pkg::*;

   // Control byte codes used by the stimulus.
   localparam logic [BYTE_W-1:0] TERM_PLAIN = 8'h00;  // count 0, ends the row
   localparam logic [BYTE_W-1:0] TERM_LIT   = 8'h80;  // literal flag, count 0: also ends
   localparam logic [BYTE_W-1:0] LIT_FLAG   = 8'h80;
   localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;

   // Worst case is far below this; it only catches a hung handshake.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      ROW_IDLE,
      WANT_CTRL,
      LITERAL_BYTES,
      REPEAT_BYTE
   } row_phase_type;

   // One transfer on the result channel, in port order.
   typedef struct packed {
      logic [WORD_W-1:0]   pixels;
      logic [COUNT_W-1:0]  lanes;
      logic [COLUMN_W-1:0] column;
      logic                row_end;
      logic                last;
      logic                overrun;
   } pixel_group_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en;
   logic [COLUMN_W-1:0] csr_wr_data;

   srrd_req_if req_chan ();
   srrd_rsp_if rsp_chan ();

   sgi_rle_row_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Decoder state as the testbench sees it; starts at the reset values.
   logic [COLUMN_W-1:0] row_width_cfg = ROW_WIDTH_RESET;
   row_phase_type       dec_phase     = ROW_IDLE;
   logic [RUN_W-1:0]    run_left      = '0;
   logic [BUDGET_W-1:0] budget_left   = '0;
   logic [COLUMN_W-1:0] cur_column    = '0;

   // Pixel groups still owed by the block, oldest first.
   pixel_group_type pending_groups[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int items_used     = 0;
   int rows_started   = 0;
   int groups_checked = 0;
   int cycle_count    = 0;

   function automatic void owe_group(input logic [WORD_W-1:0] pixels,
                                     input int unsigned lanes,
                                     input logic [COLUMN_W-1:0] column,
                                     input logic row_end, input logic last,
                                     input logic overrun);
      pending_groups.push_back('{pixels, COUNT_W'(lanes), column, row_end, last, overrun});
   endfunction

   // Advance the decoder by one accepted byte and queue what it must emit.
   // Returns 0 when the byte is ignored (idle, no row start).
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic rs,
                                      input logic [BUDGET_W-1:0] bud);
      logic [RUN_W-1:0] cnt;
      logic             ends;
      logic             ovr;
      int unsigned      avail, keep, lanes;
      logic [WORD_W-1:0] word;

      // A row start restarts the row whatever state we were in.
      if (rs) begin
         budget_left = bud;
         cur_column  = '0;
         dec_phase   = WANT_CTRL;
         rows_started++;
      end

      case (dec_phase)
         ROW_IDLE: begin
            return 1'b0;
         end
         WANT_CTRL: begin
            cnt = b[RUN_W-1:0] & CTRL_COUNT_MASK;
            if (cnt == '0) begin
               dec_phase = ROW_IDLE;
               owe_group('0, 0, cur_column, 1'b1, 1'b1, 1'b0);
            end else begin
               run_left  = cnt;
               dec_phase = b[CTRL_LIT_BIT] ? LITERAL_BYTES : REPEAT_BYTE;
            end
         end
         LITERAL_BYTES: begin
            // Budget gone: the byte is still emitted, but the row ends.
            ends = (budget_left == '0);
            if (!ends) budget_left = budget_left - BUDGET_W'(1);
            run_left = run_left - RUN_W'(1);
            if (ends) dec_phase = ROW_IDLE;
            else if (run_left == '0) dec_phase = WANT_CTRL;
            if (cur_column < row_width_cfg) begin
               owe_group(WORD_W'(b), 1, cur_column, ends, 1'b1, 1'b0);
               cur_column = cur_column + COLUMN_W'(1);
            end else begin
               owe_group('0, 0, cur_column, ends, 1'b1, 1'b1);
            end
         end
         REPEAT_BYTE: begin
            if (budget_left == '0) begin
               // Budget gone: the whole run is thrown away.
               dec_phase = ROW_IDLE;
               run_left  = '0;
               owe_group('0, 0, cur_column, 1'b1, 1'b1, 1'b0);
            end else begin
               budget_left = budget_left - BUDGET_W'(1);
               avail = (row_width_cfg > cur_column) ? 32'(row_width_cfg - cur_column) : 0;
               keep  = (32'(run_left) < avail) ? 32'(run_left) : avail;
               ovr   = (keep < 32'(run_left));
               run_left  = '0;
               dec_phase = WANT_CTRL;
               if (keep == 0) owe_group('0, 0, cur_column, 1'b0, 1'b1, ovr);
               while (keep > 0) begin
                  lanes = (keep < LANES) ? keep : LANES;
                  keep -= lanes;
                  word = {LANES{b}} >> (BYTE_W * (LANES - lanes));
                  owe_group(word, lanes, cur_column, 1'b0, keep == 0, (keep == 0) && ovr);
                  cur_column = cur_column + COLUMN_W'(lanes);
               end
            end
         end
         default: begin
         end
      endcase
      return 1'b1;
   endfunction

   // Offer one byte, with random idle cycles first, and wait for the transfer.
   // valid stays high afterwards so back-to-back bytes need no extra edge.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic rs,
                            input logic [BUDGET_W-1:0] bud);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.row_start  <= rs;
      req_chan.row_budget <= bud;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (decode_byte(b, rs, bud)) items_used++;
   endtask

   // Stop sending and let every owed group arrive. A trailing control byte
   // emits nothing, so go on waiting after the queue is empty for it to retire.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_groups.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_row_width(input logic [COLUMN_W-1:0] w);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      row_width_cfg = w;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Empty rows, both terminator codes, and a stray byte while idle.
   task automatic test_terminators_and_idle();
      send_byte(8'h42, 1'b0, '0);
      send_byte(TERM_PLAIN, 1'b1, '0);
      send_byte(TERM_LIT, 1'b1, BUDGET_MAX);
   endtask

   // Extreme literal values and the longest repeat run (127 -> 32 groups).
   task automatic test_literal_and_repeat();
      send_byte(LIT_FLAG | 8'd3, 1'b1, BUDGET_MAX);
      send_byte(8'h00, 1'b0, '0);
      send_byte(8'hff, 1'b0, '0);
      send_byte(8'ha5, 1'b0, '0);
      send_byte(8'h7f, 1'b0, '0);
      send_byte(8'h5a, 1'b0, '0);
      send_byte(TERM_PLAIN, 1'b0, '0);
   endtask

   // Budget runs out: literal kept with row end, repeat run discarded.
   task automatic test_budget_exhaustion();
      send_byte(LIT_FLAG | 8'd2, 1'b1, 17'd1);
      send_byte(8'h11, 1'b0, '0);
      send_byte(8'h22, 1'b0, '0);
      send_byte(8'h03, 1'b1, '0);
      send_byte(8'h44, 1'b0, '0);
   endtask

   // A row start in the middle of a literal run.
   task automatic test_row_restart();
      send_byte(LIT_FLAG | 8'd5, 1'b1, 17'd10);
      send_byte(8'h01, 1'b0, '0);
      send_byte(8'h02, 1'b1, 17'd5);
      send_byte(8'h77, 1'b0, '0);
   endtask

   // Narrow rows: partial and whole drops, then a zero width.
   task automatic test_width_overflow();
      wait_drained();
      set_row_width(16'd3);
      send_byte(8'h05, 1'b1, 17'd100);
      send_byte(8'h99, 1'b0, '0);
      send_byte(LIT_FLAG | 8'd2, 1'b0, '0);
      send_byte(8'haa, 1'b0, '0);
      send_byte(8'hbb, 1'b0, '0);
      send_byte(8'h04, 1'b0, '0);
      send_byte(8'hcc, 1'b0, '0);
      wait_drained();
      set_row_width(16'd0);
      send_byte(LIT_FLAG | 8'd1, 1'b1, 17'd4);
      send_byte(8'hdd, 1'b0, '0);
   endtask

   // Row with 1..4 packets, budget mostly exact; sometimes short, long or
   // random, and sometimes no terminator so the next row cuts it off.
   task automatic send_wellformed_row();
      int unsigned pkts, total, sel;
      int unsigned cnt[4];
      bit          lit[4];
      logic [BUDGET_W-1:0] budget;

      pkts  = $urandom_range(4, 1);
      total = 0;
      for (int p = 0; p < pkts; p++) begin
         lit[p] = 1'($urandom_range(1));
         cnt[p] = ($urandom_range(11) == 0) ? $urandom_range(127, 1) : $urandom_range(8, 1);
         total += lit[p] ? cnt[p] : 1;
      end
      sel = $urandom_range(9);
      if (sel < 6) budget = BUDGET_W'(total);
      else if (sel == 6) budget = BUDGET_W'($urandom_range(total - 1));
      else if (sel == 7) budget = BUDGET_W'(total + $urandom_range(3));
      else budget = BUDGET_W'($urandom_range(131071));

      for (int p = 0; p < pkts; p++) begin
         send_byte({lit[p], RUN_W'(cnt[p])}, p == 0, budget);
         for (int i = 0; i < (lit[p] ? cnt[p] : 1); i++)
            send_byte(BYTE_W'($urandom), 1'b0, BUDGET_W'($urandom));
      end
      if ($urandom_range(5) != 0)
         send_byte($urandom_range(1) ? TERM_LIT : TERM_PLAIN, 1'b0, BUDGET_W'($urandom));
   endtask

   // Arbitrary bytes, some of them row starts with arbitrary budgets.
   task automatic send_stray_bytes();
      int unsigned n;
      n = $urandom_range(6, 1);
      repeat (n)
         send_byte(BYTE_W'($urandom), $urandom_range(3) == 0,
                   BUDGET_W'($urandom_range(131071)));
   endtask

   task automatic test_random_rows(input logic [COLUMN_W-1:0] width, input int n_items);
      int goal;
      wait_drained();
      set_row_width(width);
      goal = items_used + n_items;
      while (items_used < goal) begin
         if ($urandom_range(99) < 75) send_wellformed_row();
         else send_stray_bytes();
         // Now and then hold off until the block has caught up completely.
         if ($urandom_range(7) == 0) wait_drained();
      end
   endtask

   // Result side: random stalls, and every transfer is compared against
   // the oldest owed group.
   always @(posedge clock) begin : check_groups
      pixel_group_type got_group, want_group;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_group = {rsp_chan.pixel_bytes, rsp_chan.byte_count, rsp_chan.start_column,
                         rsp_chan.row_end, rsp_chan.last, rsp_chan.overrun};
            if (pending_groups.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected group: bytes=%h n=%0d col=%0d end=%b last=%b ovr=%b",
                           got_group.pixels, got_group.lanes, got_group.column,
                           got_group.row_end, got_group.last, got_group.overrun);
            end else begin
               want_group = pending_groups.pop_front();
               groups_checked++;
               if (got_group !== want_group) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"group %0d mismatch: expected bytes=%h n=%0d col=%0d end=%b",
                               " last=%b ovr=%b, got bytes=%h n=%0d col=%0d end=%b",
                               " last=%b ovr=%b"},
                              groups_checked, want_group.pixels, want_group.lanes,
                              want_group.column, want_group.row_end, want_group.last,
                              want_group.overrun, got_group.pixels, got_group.lanes,
                              got_group.column, got_group.row_end, got_group.last,
                              got_group.overrun);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d groups outstanding",
                  cycle_count, pending_groups.size());
         $display("sgi_rle_row_decoder_top_test failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.row_start  <= 1'b0;
      req_chan.row_budget <= '0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under sender-light / receiver-heavy idling.
      set_idling(32, 64);
      test_terminators_and_idle();
      test_literal_and_repeat();
      test_budget_exhaustion();
      test_row_restart();
      test_width_overflow();

      test_random_rows(16'd23, 30);
      test_random_rows(16'hffff, 30);

      set_idling(64, 32);
      test_random_rows(16'd1, 20);
      test_random_rows(16'd97, 40);

      // No idling on either side.
      set_idling(0, 0);
      test_random_rows(16'd300, 55);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Decoded %0d bytes over %0d rows; %0d pixel groups checked.",
               items_used, rows_started, groups_checked);
      $display("Row widths 0 to 65535, both idling mixes and no idling; %0d failures.",
               fail_count + pending_groups.size());
      if (fail_count == 0 && pending_groups.size() == 0) begin
         $display("sgi_rle_row_decoder_top_test passed");
      end else begin
         $display("sgi_rle_row_decoder_top_test failed");
      end
      $finish;
   end

endmodule

FILE: sgi_rle_row_decoder_top.f
+incdir+hdl
hdl/srrd_pkg.sv
hdl/srrd_req_if.sv
hdl/srrd_rsp_if.sv
hdl/sgi_rle_row_decoder_top.sv
bench/sgi_rle_row_decoder_top_test.sv
